// ----- rtl/dqdel_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue with delete by value.
// Used by every module of the block; depends on nothing else.
package dqdel_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_DELETE     = 3'd4
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } stat_e;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_BACK,
        CELL_POP_BACK,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_SWEEP
    } cell_op_e;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_SWEEP
    } ctrl_state_e;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  popped_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } res_t;

    typedef struct packed {
        logic valid;
        logic tok;
        logic found;
    } link_t;

    typedef struct packed {
        logic done;
        logic hit;
    } sweep_t;

endpackage

// ----- rtl/deque_with_delete_by_value.sv -----
`timescale 1ns / 1ps
// Push, pop and unused requests, and a delete on an empty queue, give their registered result
// in the cycle after they are taken, and the next request may be taken in that same cycle.
// A delete on a non-empty queue walks a token down the row of slots, one slot a cycle:
// busy stays high until the token reaches the last held entry, and the result follows in the
// cycle after the last busy cycle; no new request is taken while busy is high.
// The receiver cannot stall. Reset empties the queue at once; slot words are not cleared.
module deque_with_delete_by_value #(
    parameter int DEPTH      = dqdel_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dqdel_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dqdel_pkg::req_t   request,
    output logic              done,
    output dqdel_pkg::res_t   result
);

    dqdel_pkg::cell_op_e    op;
    logic [DATA_WIDTH-1:0]  word;
    logic                   launch;
    dqdel_pkg::link_t       link_vec [DEPTH];
    logic [DATA_WIDTH-1:0]  data_vec [DEPTH];
    logic [DATA_WIDTH-1:0]  tail_vec [DEPTH];
    dqdel_pkg::sweep_t      sweep_vec [DEPTH];
    logic [DEPTH-1:0]       done_bits;
    logic [DATA_WIDTH-1:0]  back_data;
    dqdel_pkg::sweep_t      sweep;

    dqdel_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .request    (request),
        .front_data (data_vec[0]),
        .back_data  (back_data),
        .sweep      (sweep),
        .busy       (busy),
        .op         (op),
        .word       (word),
        .launch     (launch),
        .done       (done),
        .result     (result)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dqdel_pkg::link_t      left_link;
        logic [DATA_WIDTH-1:0] left_data;
        logic                  right_valid;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_link.valid = 1'b1;
            assign left_link.tok   = launch;
            assign left_link.found = 1'b0;
            assign left_data       = word;
        end
        else
        begin : g_inner
            assign left_link = link_vec[i-1];
            assign left_data = data_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_valid = 1'b0;
            assign right_data  = '0;
        end
        else
        begin : g_body
            assign right_valid = link_vec[i+1].valid;
            assign right_data  = data_vec[i+1];
        end

        dqdel_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .word        (word),
            .left_link   (left_link),
            .left_data   (left_data),
            .right_valid (right_valid),
            .right_data  (right_data),
            .link        (link_vec[i]),
            .data        (data_vec[i]),
            .tail_data   (tail_vec[i]),
            .sweep       (sweep_vec[i])
        );

        assign done_bits[i] = sweep_vec[i].done;
    end

    always_comb
    begin
        back_data  = '0;
        sweep.done = 1'b0;
        sweep.hit  = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data  = back_data | tail_vec[i];
            sweep.done = sweep.done | sweep_vec[i].done;
            sweep.hit  = sweep.hit | (sweep_vec[i].done & sweep_vec[i].hit);
        end
    end

`ifndef SYNTHESIS
    a_one_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(done_bits))
        else $error("delete sweep ended in more than one slot");
`endif

endmodule

// ----- rtl/dqdel_cell.sv -----
`timescale 1ns / 1ps
// One slot of the queue: a data word, its valid bit and the delete sweep token.
// Depends on dqdel_pkg.
module dqdel_cell #(
    parameter int DATA_WIDTH = dqdel_pkg::DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dqdel_pkg::cell_op_e      op,
    input  logic [DATA_WIDTH-1:0]    word,
    input  dqdel_pkg::link_t         left_link,
    input  logic [DATA_WIDTH-1:0]    left_data,
    input  logic                     right_valid,
    input  logic [DATA_WIDTH-1:0]    right_data,
    output dqdel_pkg::link_t         link,
    output logic [DATA_WIDTH-1:0]    data,
    output logic [DATA_WIDTH-1:0]    tail_data,
    output dqdel_pkg::sweep_t        sweep
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  tok_reg;
    logic                  tok_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  last;
    logic                  hit;

    assign last = valid_reg & ~right_valid;
    assign hit  = left_link.tok & (left_link.found | (data_reg == word));

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        tok_next   = 1'b0;
        found_next = 1'b0;
        case (op)
            dqdel_pkg::CELL_PUSH_BACK:
            begin
                if (!valid_reg && left_link.valid)
                begin
                    valid_next = 1'b1;
                    data_next  = word;
                end
            end
            dqdel_pkg::CELL_POP_BACK:
            begin
                if (last)
                begin
                    valid_next = 1'b0;
                end
            end
            dqdel_pkg::CELL_SHIFT_UP:
            begin
                valid_next = left_link.valid;
                data_next  = left_data;
            end
            dqdel_pkg::CELL_SHIFT_DOWN:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            dqdel_pkg::CELL_SWEEP:
            begin
                tok_next   = left_link.tok & ~last;
                found_next = hit;
                if (hit)
                begin
                    data_next = right_data;
                    if (last)
                    begin
                        valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign link.valid = valid_reg;
    assign link.tok   = tok_reg;
    assign link.found = found_reg;
    assign data       = data_reg;
    assign tail_data  = last ? data_reg : '0;
    assign sweep.done = left_link.tok & last;
    assign sweep.hit  = hit;

endmodule

// ----- rtl/dqdel_ctrl.sv -----
`timescale 1ns / 1ps
// Command decoder, entry count and result register of the queue.
// Depends on dqdel_pkg; drives the row of dqdel_cell slots.
module dqdel_ctrl #(
    parameter int DEPTH      = dqdel_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dqdel_pkg::DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  dqdel_pkg::req_t          request,
    input  logic [DATA_WIDTH-1:0]    front_data,
    input  logic [DATA_WIDTH-1:0]    back_data,
    input  dqdel_pkg::sweep_t        sweep,
    output logic                     busy,
    output dqdel_pkg::cell_op_e      op,
    output logic [DATA_WIDTH-1:0]    word,
    output logic                     launch,
    output logic                     done,
    output dqdel_pkg::res_t          result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    dqdel_pkg::ctrl_state_e state_reg;
    dqdel_pkg::ctrl_state_e state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [DATA_WIDTH-1:0]  word_reg;
    logic [DATA_WIDTH-1:0]  word_next;
    logic                   launch_reg;
    logic                   launch_next;
    logic                   done_reg;
    logic                   done_next;
    dqdel_pkg::res_t        result_reg;
    dqdel_pkg::res_t        result_next;
    logic [DATA_WIDTH-1:0]  popped;
    dqdel_pkg::stat_e       status;
    logic                   empty;
    logic                   full;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        word_next   = word_reg;
        launch_next = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        op          = dqdel_pkg::CELL_HOLD;
        word        = DATA_WIDTH'(request.data_value);
        popped      = '0;
        status      = dqdel_pkg::STAT_OK;
        busy        = (state_reg == dqdel_pkg::CTRL_SWEEP);
        unique case (state_reg)
            dqdel_pkg::CTRL_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (request.cmd)
                        dqdel_pkg::CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status = dqdel_pkg::STAT_FULL;
                            end
                            else
                            begin
                                op         = dqdel_pkg::CELL_PUSH_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        dqdel_pkg::CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status = dqdel_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                op         = dqdel_pkg::CELL_POP_BACK;
                                popped     = back_data;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        dqdel_pkg::CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status = dqdel_pkg::STAT_FULL;
                            end
                            else
                            begin
                                op         = dqdel_pkg::CELL_SHIFT_UP;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        dqdel_pkg::CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status = dqdel_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                op         = dqdel_pkg::CELL_SHIFT_DOWN;
                                popped     = front_data;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        dqdel_pkg::CMD_DELETE:
                        begin
                            if (empty)
                            begin
                                status = dqdel_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                done_next   = 1'b0;
                                word_next   = DATA_WIDTH'(request.data_value);
                                launch_next = 1'b1;
                                state_next  = dqdel_pkg::CTRL_SWEEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dqdel_pkg::CTRL_SWEEP:
            begin
                op   = dqdel_pkg::CELL_SWEEP;
                word = word_reg;
                if (sweep.done)
                begin
                    done_next  = 1'b1;
                    state_next = dqdel_pkg::CTRL_IDLE;
                    if (sweep.hit)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status = dqdel_pkg::STAT_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = dqdel_pkg::CTRL_IDLE;
            end
        endcase
        if (done_next)
        begin
            result_next.popped_value = dqdel_pkg::VALUE_W'(popped);
            result_next.status       = status;
            result_next.entry_count  = dqdel_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dqdel_pkg::CTRL_IDLE;
            count_reg  <= '0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    assign launch = launch_reg;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_count_shown: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.entry_count == dqdel_pkg::COUNT_W'(count_reg)))
        else $error("reported count differs from held count");

    a_sweep_state: assert property (@(posedge clk) disable iff (!rst_n)
        (sweep.done || launch_reg) |-> (state_reg == dqdel_pkg::CTRL_SWEEP))
        else $error("sweep activity outside of a delete");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.cmd != dqdel_pkg::CMD_DELETE)) |=> done_reg)
        else $error("request without a result in the next cycle");
`endif

endmodule
